FILE: rtl/gof_pkg.sv
package gof_pkg;

   // Fraction bits of the curve parameter t.
   localparam int FRAC_BITS = 16;

   // Width of the steps register and its upper bound.
   localparam int STEPS_BITS = 6;
   localparam logic [STEPS_BITS-1:0] MAX_STEPS = 6'd62;
   localparam logic [STEPS_BITS-1:0] STEPS_RESET = 6'd4;

   // Point kind codes.
   localparam logic [1:0] KIND_ON_CURVE = 2'd0;
   localparam logic [1:0] KIND_CONIC = 2'd1;

   // Configuration register addresses.
   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEPS_ADDR = 2'd0;

   // Step sizes for t that the reciprocal unit hands to the back end.
   typedef struct packed {
      logic                  ready;
      logic [FRAC_BITS-1:0]  quot;
      logic [STEPS_BITS-1:0] rem;
   } recip_type;

endpackage

FILE: rtl/gof_fifo.sv
module gof_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH):0]     count
);

   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/gof_recip.sv
module gof_recip (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gof_pkg::STEPS_BITS-1:0] steps,
   output gof_pkg::recip_type            recip
);

   import gof_pkg::*;

   localparam int DW = STEPS_BITS + 1;
   localparam int CW = $clog2(FRAC_BITS + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [FRAC_BITS:0] quot_ff, quot_in;
   logic [DW-1:0] divisor;
   logic [DW-1:0] rem_shift;
   logic          dividend_bit;

   // The divisor is the number of intervals, steps plus one.
   assign divisor = {1'b0, steps} + 1'b1;

   assign recip.ready = !busy_ff && (div_ff == divisor);
   assign recip.quot  = quot_ff[FRAC_BITS-1:0];
   assign recip.rem   = rem_ff[STEPS_BITS-1:0];

   // Restoring division of 2**FRAC_BITS by the divisor, one quotient bit per cycle.
   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      dividend_bit = (cnt_ff == CW'(FRAC_BITS));
      rem_shift    = {rem_ff[DW-2:0], dividend_bit};
      if (busy_ff) begin
         if (rem_shift >= div_ff) begin
            rem_in  = rem_shift - div_ff;
            quot_in = {quot_ff[FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            quot_in = {quot_ff[FRAC_BITS-1:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end else if (div_ff != divisor) begin
         busy_in = 1'b1;
         div_in  = divisor;
         cnt_in  = CW'(FRAC_BITS);
         rem_in  = '0;
         quot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         div_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         div_ff  <= div_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

endmodule

FILE: rtl/gof_front.sv
module gof_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic [1:0]                   point_kind,
   input  logic                         outline_start,
   output logic                         cmd_push,
   output logic [6*COORD_BITS:0]        cmd_data
);

   import gof_pkg::*;

   localparam int CB = COORD_BITS;

   logic                 anchor_valid_ff, anchor_valid_in;
   logic                 control_pending_ff, control_pending_in;
   logic signed [CB-1:0] anchor_x_ff, anchor_x_in;
   logic signed [CB-1:0] anchor_y_ff, anchor_y_in;
   logic signed [CB-1:0] control_x_ff, control_x_in;
   logic signed [CB-1:0] control_y_ff, control_y_in;
   logic                 av, cp;
   logic                 curve;
   logic signed [CB-1:0] end_x, end_y;
   logic [CB:0]          sum_x, sum_y;
   logic [CB:0]          adj_x, adj_y;
   logic signed [CB-1:0] mid_x, mid_y;

   // Virtual on-curve midpoint of two conics, truncated toward zero.
   always_comb begin
      sum_x = {control_x_ff[CB-1], control_x_ff} + {point_x[CB-1], point_x};
      sum_y = {control_y_ff[CB-1], control_y_ff} + {point_y[CB-1], point_y};
      adj_x = sum_x + {{CB{1'b0}}, sum_x[CB]};
      adj_y = sum_y + {{CB{1'b0}}, sum_y[CB]};
      mid_x = adj_x[CB:1];
      mid_y = adj_y[CB:1];
   end

   // Classify the point and build the segment command for the back end.
   always_comb begin
      av                 = outline_start ? 1'b0 : anchor_valid_ff;
      cp                 = outline_start ? 1'b0 : control_pending_ff;
      anchor_valid_in    = anchor_valid_ff;
      control_pending_in = control_pending_ff;
      anchor_x_in        = anchor_x_ff;
      anchor_y_in        = anchor_y_ff;
      control_x_in       = control_x_ff;
      control_y_in       = control_y_ff;
      cmd_push           = 1'b0;
      curve              = 1'b0;
      end_x              = point_x;
      end_y              = point_y;
      if (accept) begin
         anchor_valid_in    = av;
         control_pending_in = cp;
         if (point_kind == KIND_ON_CURVE) begin
            cmd_push           = 1'b1;
            curve              = cp && av;
            anchor_x_in        = point_x;
            anchor_y_in        = point_y;
            anchor_valid_in    = 1'b1;
            control_pending_in = 1'b0;
         end else if (point_kind == KIND_CONIC) begin
            if (cp) begin
               cmd_push        = 1'b1;
               curve           = av;
               end_x           = mid_x;
               end_y           = mid_y;
               anchor_x_in     = mid_x;
               anchor_y_in     = mid_y;
               anchor_valid_in = 1'b1;
            end
            control_x_in       = point_x;
            control_y_in       = point_y;
            control_pending_in = 1'b1;
         end
      end
      cmd_data = {curve, anchor_x_ff, anchor_y_ff, control_x_ff, control_y_ff, end_x, end_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_valid_ff    <= 1'b0;
         control_pending_ff <= 1'b0;
      end else begin
         anchor_valid_ff    <= anchor_valid_in;
         control_pending_ff <= control_pending_in;
      end
   end

   // Coordinates are read only while their valid flag is set.
   always_ff @(posedge clock) begin
      anchor_x_ff  <= anchor_x_in;
      anchor_y_ff  <= anchor_y_in;
      control_x_ff <= control_x_in;
      control_y_ff <= control_y_in;
   end

endmodule

FILE: rtl/gof_back.sv
module gof_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [gof_pkg::STEPS_BITS-1:0] steps,
   input  gof_pkg::recip_type             recip,
   input  logic                           cmd_empty,
   input  logic [6*COORD_BITS:0]          cmd_data,
   output logic                           cmd_pop,
   output logic signed [COORD_BITS-1:0]   vertex_x,
   output logic signed [COORD_BITS-1:0]   vertex_y,
   output logic                           last_of_run,
   output logic                           empty,
   input  logic                           pop
);

   import gof_pkg::*;

   localparam int CB        = COORD_BITS;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_W     = 2 * CB + 1;
   localparam int PW        = CB + FRAC_BITS + 3;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CURVE = 3'b010,
      ST_END   = 3'b100
   } seq_state_type;

   seq_state_type             state_ff, state_in;
   logic [STEPS_BITS-1:0]     k_ff, k_in;
   logic [FRAC_BITS-1:0]      t_ff, t_in;
   logic [STEPS_BITS-1:0]     rem_ff, rem_in;
   logic [STEPS_BITS:0]       rem_sum;
   logic [STEPS_BITS:0]       divisor;

   logic                      va_ff, va_in;
   logic                      a_pass_ff, a_pass_in;
   logic                      a_last_ff, a_last_in;
   logic [FRAC_BITS-1:0]      a_t_ff, a_t_in;
   logic signed [CB-1:0]      a_x0_ff, a_x0_in, a_y0_ff, a_y0_in;
   logic signed [CB-1:0]      a_x1_ff, a_x1_in, a_y1_ff, a_y1_in;

   logic                      cmd_curve;
   logic signed [CB-1:0]      p0x, p0y, p1x, p1y, p2x, p2y;
   logic                      credit;
   logic                      issue_interior, issue_end;
   logic                      out_push, out_full;
   logic [OUT_W-1:0]          out_push_data, out_pop_data;
   logic [$clog2(OUT_DEPTH):0] out_count;
   logic signed [CB-1:0]      fin_x, fin_y;

   // Q16 lerp a + (b - a) * t, truncated toward zero.
   function automatic logic signed [CB-1:0] lerp(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b,
                                                input logic [FRAC_BITS-1:0] t);
      logic signed [CB:0]   diff;
      logic signed [PW-1:0] prod;
      logic signed [PW-1:0] s;
      logic signed [PW-1:0] adj;
      diff = {b[CB-1], b} - {a[CB-1], a};
      prod = diff * $signed({1'b0, t});
      s    = $signed({{3{a[CB-1]}}, a, {FRAC_BITS{1'b0}}}) + prod;
      adj  = s + $signed({{(CB+3){1'b0}}, {FRAC_BITS{s[PW-1]}}});
      return adj[CB+FRAC_BITS-1:FRAC_BITS];
   endfunction

   assign {cmd_curve, p0x, p0y, p1x, p1y, p2x, p2y} = cmd_data;
   assign divisor = {1'b0, steps} + 1'b1;
   assign rem_sum = {1'b0, rem_ff} + {1'b0, recip.rem};

   // Room for an issued vertex once everything in flight has landed.
   assign credit = (out_count + {{($clog2(OUT_DEPTH)){1'b0}}, va_ff})
                   < ($clog2(OUT_DEPTH)+1)'(OUT_DEPTH);

   // Segment sequencer: interior vertices one per cycle while credit holds, then the end vertex.
   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      t_in           = t_ff;
      rem_in         = rem_ff;
      cmd_pop        = 1'b0;
      issue_interior = 1'b0;
      issue_end      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (cmd_curve && steps != '0) begin
                  if (recip.ready) begin
                     t_in     = recip.quot;
                     rem_in   = recip.rem;
                     k_in     = STEPS_BITS'(1);
                     state_in = ST_CURVE;
                  end
               end else begin
                  state_in = ST_END;
               end
            end
         end
         ST_CURVE: begin
            if (credit) begin
               issue_interior = 1'b1;
               k_in           = k_ff + 1'b1;
               if (rem_sum >= divisor) begin
                  rem_in = STEPS_BITS'(rem_sum - divisor);
                  t_in   = t_ff + recip.quot + 1'b1;
               end else begin
                  rem_in = rem_sum[STEPS_BITS-1:0];
                  t_in   = t_ff + recip.quot;
               end
               if (k_ff == steps) begin
                  state_in = ST_END;
               end
            end
         end
         ST_END: begin
            if (credit) begin
               issue_end = 1'b1;
               cmd_pop   = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // First de Casteljau level, or the end point passed through.
   always_comb begin
      va_in     = issue_interior || issue_end;
      a_pass_in = issue_end;
      a_last_in = issue_end;
      a_t_in    = t_ff;
      if (issue_end) begin
         a_x0_in = p2x;
         a_y0_in = p2y;
         a_x1_in = p2x;
         a_y1_in = p2y;
      end else begin
         a_x0_in = lerp(p0x, p1x, t_ff);
         a_y0_in = lerp(p0y, p1y, t_ff);
         a_x1_in = lerp(p1x, p2x, t_ff);
         a_y1_in = lerp(p1y, p2y, t_ff);
      end
   end

   // Second level feeds the result queue.
   always_comb begin
      if (a_pass_ff) begin
         fin_x = a_x0_ff;
         fin_y = a_y0_ff;
      end else begin
         fin_x = lerp(a_x0_ff, a_x1_ff, a_t_ff);
         fin_y = lerp(a_y0_ff, a_y1_ff, a_t_ff);
      end
      out_push      = va_ff;
      out_push_data = {fin_x, fin_y, a_last_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         va_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         va_ff    <= va_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      t_ff      <= t_in;
      rem_ff    <= rem_in;
      a_pass_ff <= a_pass_in;
      a_last_ff <= a_last_in;
      a_t_ff    <= a_t_in;
      a_x0_ff   <= a_x0_in;
      a_y0_ff   <= a_y0_in;
      a_x1_ff   <= a_x1_in;
      a_y1_ff   <= a_y1_in;
   end

   gof_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_push_data),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_pop_data),
      .empty     (empty),
      .count     (out_count)
   );

   assign vertex_x    = out_pop_data[OUT_W-1:CB+1];
   assign vertex_y    = out_pop_data[CB:1];
   assign last_of_run = out_pop_data[0] && !out_full | out_pop_data[0];

endmodule

FILE: rtl/glyph_outline_flattener.sv
// Quadratic outline flattener. Outline points enter one per transfer and
// the flattened vertex list leaves one vertex per transfer, with
// last_of_run set on the final vertex that a point causes (points that
// cause none produce no transfer). The front end queues at most one
// segment command per point. The segment queue holds two commands, and
// the one that the back end is working on stays in it until its end
// vertex is issued, so full rises once two segments are held.
// The back end runs one segment at a time: it takes the segment, then
// issues each interior vertex and then the end vertex, waiting whenever
// the result queue lacks room. A point that closes a curve yields
// steps_per_curve interior vertices and then its end vertex;
// steps_per_curve resets to four.
// Issued vertices pass through a two-level de Casteljau pipeline, whose
// first level is registered, into a four-entry result queue. The step
// of t comes from a bit-serial divider that restarts after reset or
// after steps_per_curve changes; no curve can start until it is done.
// steps_per_curve sits at address 0 and saturates at 62.
module glyph_outline_flattener #(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Point input.
   input  logic                                 push,
   output logic                                 full,
   input  logic signed [COORD_BITS-1:0]         req_point_x,
   input  logic signed [COORD_BITS-1:0]         req_point_y,
   input  logic [1:0]                           req_point_kind,
   input  logic                                 req_outline_start,
   // Vertex output.
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [COORD_BITS-1:0]         rsp_vertex_x,
   output logic signed [COORD_BITS-1:0]         rsp_vertex_y,
   output logic                                 rsp_last_of_run,
   // Configuration port.
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gof_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   import gof_pkg::*;

   localparam int CMD_W     = 6 * COORD_BITS + 1;
   localparam int CMD_DEPTH = 2;

   logic [STEPS_BITS-1:0] steps_ff, steps_in;
   logic [STEPS_BITS-1:0] steps_sat;
   logic                  csr_write;
   logic                  accept;
   logic                  cmd_push, cmd_pop, cmd_empty;
   logic [CMD_W-1:0]      cmd_push_data, cmd_pop_data;
   recip_type             recip;

   // Configuration register write and readback.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == CSR_STEPS_ADDR);
   assign steps_in  = csr_write ? pwdata[STEPS_BITS-1:0] : steps_ff;
   assign prdata    = (paddr == CSR_STEPS_ADDR) ? {{(32-STEPS_BITS){1'b0}}, steps_ff} : '0;
   assign steps_sat = (steps_ff > MAX_STEPS) ? MAX_STEPS : steps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= STEPS_RESET;
      end else begin
         steps_ff <= steps_in;
      end
   end

   assign accept = push && !full;

   gof_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .point_x       (req_point_x),
      .point_y       (req_point_y),
      .point_kind    (req_point_kind),
      .outline_start (req_outline_start),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_push_data)
   );

   // Segment queue between front and back.
   gof_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .empty     (cmd_empty),
      .count     ()
   );

   gof_recip u_recip (
      .clock (clock),
      .reset (reset),
      .steps (steps_sat),
      .recip (recip)
   );

   gof_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .steps       (steps_sat),
      .recip       (recip),
      .cmd_empty   (cmd_empty),
      .cmd_data    (cmd_pop_data),
      .cmd_pop     (cmd_pop),
      .vertex_x    (rsp_vertex_x),
      .vertex_y    (rsp_vertex_y),
      .last_of_run (rsp_last_of_run),
      .empty       (empty),
      .pop         (pop)
   );

endmodule

FILE: tb/glyph_outline_flattener_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the flattener. It keeps
// its own copy of the outline state, works out the vertices that every point
// transfer causes, and compares each vertex transfer with the oldest of them.
module glyph_outline_flattener_checker #(
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic                              full,
   input  logic signed [COORD_BITS-1:0]      req_point_x,
   input  logic signed [COORD_BITS-1:0]      req_point_y,
   input  logic [1:0]                        req_point_kind,
   input  logic                              req_outline_start,
   input  logic                              empty,
   input  logic                              pop,
   input  logic signed [COORD_BITS-1:0]      rsp_vertex_x,
   input  logic signed [COORD_BITS-1:0]      rsp_vertex_y,
   input  logic                              rsp_last_of_run,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gof_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]                       pwdata,
   input  logic                              pready,
   output int                                fail_count,
   output int                                pending,
   output int                                checked
);
   import gof_pkg::*;

   localparam longint Q_ONE = longint'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         last;
   } vertex_type;

   // Shadow of the steps register and of the outline state.
   logic [STEPS_BITS-1:0] steps_shadow;
   longint                anchor_x, anchor_y, control_x, control_y;
   logic                  anchor_valid, control_pending;

   vertex_type expected_vertices[$];
   int         run_length;

   // Truncating Q16 interpolation between a and b.
   function automatic longint blend(longint a, longint b, longint t);
      longint s;
      s = a * (Q_ONE - t) + b * t;
      return s / Q_ONE;
   endfunction

   task automatic add_vertex(longint x, longint y);
      vertex_type v;
      v.x = x[COORD_BITS-1:0];
      v.y = y[COORD_BITS-1:0];
      v.last = 1'b0;
      expected_vertices.insert(expected_vertices.size(), v);
      run_length++;
   endtask

   // Interior points of the segment from the anchor through the control point.
   task automatic add_curve(longint ex, longint ey);
      int     steps;
      longint t, ax, ay, bx, by;
      steps = (steps_shadow > MAX_STEPS) ? MAX_STEPS : steps_shadow;
      for (int k = 1; k <= steps; k++) begin
         t = (longint'(k) * Q_ONE) / longint'(steps + 1);
         ax = blend(anchor_x, control_x, t);
         ay = blend(anchor_y, control_y, t);
         bx = blend(control_x, ex, t);
         by = blend(control_y, ey, t);
         add_vertex(blend(ax, bx, t), blend(ay, by, t));
      end
   endtask

   // Expected vertices for one accepted outline point.
   task automatic flatten_point(longint px, longint py, logic [1:0] kind, logic start);
      longint     mx, my;
      vertex_type tail;
      run_length = 0;
      if (start) begin
         anchor_x = 0;
         anchor_y = 0;
         control_x = 0;
         control_y = 0;
         anchor_valid = 1'b0;
         control_pending = 1'b0;
      end
      if (kind == KIND_ON_CURVE) begin
         if (control_pending && anchor_valid) begin
            add_curve(px, py);
         end
         add_vertex(px, py);
         anchor_x = px;
         anchor_y = py;
         anchor_valid = 1'b1;
         control_pending = 1'b0;
      end else if (kind == KIND_CONIC) begin
         // Two conics in a row imply an on-curve point halfway between them.
         if (control_pending) begin
            mx = (control_x + px) / 2;
            my = (control_y + py) / 2;
            if (anchor_valid) begin
               add_curve(mx, my);
            end
            add_vertex(mx, my);
            anchor_x = mx;
            anchor_y = my;
            anchor_valid = 1'b1;
         end
         control_x = px;
         control_y = py;
         control_pending = 1'b1;
      end
      if (run_length > 0) begin
         tail = expected_vertices[expected_vertices.size() - 1];
         tail.last = 1'b1;
         expected_vertices[expected_vertices.size() - 1] = tail;
      end
   endtask

   // Compare one vertex transfer with the oldest expectation.
   task automatic check_vertex();
      vertex_type want;
      if (expected_vertices.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected vertex (%0d, %0d, last %0b)", $time,
                  rsp_vertex_x, rsp_vertex_y, rsp_last_of_run);
      end else begin
         want = expected_vertices.pop_front();
         checked++;
         if (rsp_vertex_x !== want.x || rsp_vertex_y !== want.y ||
             rsp_last_of_run !== want.last) begin
            fail_count++;
            $display("%0t: vertex mismatch: expected (%0d, %0d, last %0b), got (%0d, %0d, last %0b)",
                     $time, want.x, want.y, want.last,
                     rsp_vertex_x, rsp_vertex_y, rsp_last_of_run);
         end
      end
   endtask

   // Results are taken before points, since a point never yields a vertex
   // in the cycle it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         steps_shadow = STEPS_RESET;
         anchor_x = 0;
         anchor_y = 0;
         control_x = 0;
         control_y = 0;
         anchor_valid = 1'b0;
         control_pending = 1'b0;
         expected_vertices.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (pop && !empty) begin
            check_vertex();
         end
         if (psel && penable && pwrite && pready && paddr == CSR_STEPS_ADDR) begin
            steps_shadow = pwdata[STEPS_BITS-1:0];
         end
         if (push && !full) begin
            flatten_point(longint'(req_point_x), longint'(req_point_y),
                          req_point_kind, req_outline_start);
         end
      end
      pending = expected_vertices.size();
   end

endmodule

FILE: tb/glyph_outline_flattener_test.sv
`timescale 1ns / 1ps

module glyph_outline_flattener_test;
   import gof_pkg::*;

   localparam int COORD_BITS = 16;
   localparam logic [1:0] KIND_CUBIC = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   // Enough for two queued segments of the longest curve plus the divider.
   localparam int SETTLE_CYCLES = 150;
   localparam int DRAIN_LIMIT = 200000;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                         clock;
   logic                         reset;
   logic                         push;
   logic                         full;
   logic signed [COORD_BITS-1:0] req_point_x;
   logic signed [COORD_BITS-1:0] req_point_y;
   logic [1:0]                   req_point_kind;
   logic                         req_outline_start;
   logic                         empty;
   logic                         pop;
   logic signed [COORD_BITS-1:0] rsp_vertex_x;
   logic signed [COORD_BITS-1:0] rsp_vertex_y;
   logic                         rsp_last_of_run;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [CSR_ADDR_BITS-1:0]     paddr;
   logic [31:0]                  pwdata;
   logic [31:0]                  prdata;
   logic                         pready;

   int check_failures;
   int vertices_waiting;
   int vertices_checked;
   int points_sent = 0;
   int settings_used = 0;
   bit calm = 1'b0;
   bit long_hold_req = 1'b0;

   glyph_outline_flattener #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_point_kind(req_point_kind),
      .req_outline_start(req_outline_start),
      .empty(empty),
      .pop(pop),
      .rsp_vertex_x(rsp_vertex_x),
      .rsp_vertex_y(rsp_vertex_y),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   glyph_outline_flattener_checker #(
      .COORD_BITS(COORD_BITS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_point_x(req_point_x),
      .req_point_y(req_point_y),
      .req_point_kind(req_point_kind),
      .req_outline_start(req_outline_start),
      .empty(empty),
      .pop(pop),
      .rsp_vertex_x(rsp_vertex_x),
      .rsp_vertex_y(rsp_vertex_y),
      .rsp_last_of_run(rsp_last_of_run),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .pready(pready),
      .fail_count(check_failures),
      .pending(vertices_waiting),
      .checked(vertices_checked)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

   // Vertex side: random stall bursts, one long hold-off on request, and none
   // once the run has turned calm.
   initial begin : drain_side
      int hold_left;
      hold_left = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            pop <= 1'b0;
         end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            pop <= 1'b0;
            hold_left = LONG_HOLD_CYCLES - 1;
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            pop <= 1'b0;
            hold_left = $urandom_range(0, 17);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Offer one point and hold it until the transfer; push stays high after.
   task automatic send_point(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                             logic [1:0] kind, logic start);
      push <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_kind <= kind;
      req_outline_start <= start;
      do @(posedge clock); while (full);
      points_sent++;
   endtask

   task automatic idle_sender(int cycles);
      push <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop offering points and wait until every expected vertex has come.
   task automatic wait_drained(int extra);
      int spins;
      spins = 0;
      push <= 1'b0;
      while (vertices_waiting != 0 && spins < DRAIN_LIMIT) begin
         @(posedge clock);
         spins++;
      end
      repeat (extra) @(posedge clock);
   endtask

   // Setup cycle, then access cycle until pready.
   task automatic set_steps(logic [STEPS_BITS-1:0] steps);
      logic [31:0] data;
      wait_drained(SETTLE_CYCLES);
      data = $urandom();
      data[STEPS_BITS-1:0] = steps;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_STEPS_ADDR;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings_used++;
   endtask

   // Mostly full-range coordinates, with extremes and small values mixed in.
   function automatic logic signed [COORD_BITS-1:0] random_coord();
      int v;
      case ($urandom_range(0, 9))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2, 3: begin
            v = $urandom_range(0, 200) - 100;
            return v[COORD_BITS-1:0];
         end
         default: begin
            v = $urandom();
            return v[COORD_BITS-1:0];
         end
      endcase
   endfunction

   // Random outlines: each usually opens with a restart on an on-curve point
   // and then mixes on-curve points and conic chains, with a little noise.
   task automatic random_points(int target);
      int         done;
      int         len;
      int         pick;
      logic [1:0] kind;
      logic       start;
      done = 0;
      while (done < target) begin
         len = $urandom_range(1, 9);
         for (int i = 0; i < len && done < target; i++) begin
            pick = $urandom_range(0, 99);
            if (i == 0) begin
               start = ($urandom_range(0, 9) != 0);
               kind = (pick < 20) ? KIND_CONIC : KIND_ON_CURVE;
            end else begin
               start = ($urandom_range(0, 29) == 0);
               if (pick < 50) kind = KIND_CONIC;
               else if (pick < 90) kind = KIND_ON_CURVE;
               else if (pick < 95) kind = KIND_CUBIC;
               else kind = KIND_SPARE;
            end
            send_point(random_coord(), random_coord(), kind, start);
            if (kind == KIND_ON_CURVE || kind == KIND_CONIC) begin
               done++;
            end
            if (!calm && $urandom_range(0, 7) == 0) begin
               idle_sender($urandom_range(1, 18));
            end
         end
      end
   endtask

   // Directed points at the reset setting of four steps.
   task automatic directed_points();
      // Full-range curve whose control point sits in the corner opposite its start.
      send_point(COORD_MIN, COORD_MIN, KIND_ON_CURVE, 1'b1);
      send_point(COORD_MAX, COORD_MAX, KIND_CONIC, 1'b0);
      send_point(COORD_MIN, COORD_MAX, KIND_ON_CURVE, 1'b0);
      // Conic chain; the midpoints of odd negative sums truncate toward zero.
      send_point(COORD_MAX, COORD_MIN, KIND_CONIC, 1'b0);
      send_point(COORD_MIN, COORD_MAX, KIND_CONIC, 1'b0);
      send_point(-16'sd3, 16'sd5, KIND_CONIC, 1'b0);
      send_point(16'sd0, 16'sd0, KIND_ON_CURVE, 1'b0);
      // Cubic and unused kinds cause nothing.
      send_point(COORD_MAX, COORD_MAX, KIND_CUBIC, 1'b0);
      send_point(COORD_MIN, COORD_MIN, KIND_SPARE, 1'b0);
      // A conic without an anchor is only stored; the next conic makes the
      // midpoint the first anchor.
      send_point(16'sd100, -16'sd100, KIND_CONIC, 1'b1);
      send_point(-16'sd101, 16'sd201, KIND_CONIC, 1'b0);
      send_point(16'sd5, 16'sd5, KIND_ON_CURVE, 1'b0);
      // An on-curve point after an unanchored control drops the control.
      send_point(16'sd7, -16'sd9, KIND_CONIC, 1'b1);
      send_point(-16'sd1, -16'sd1, KIND_ON_CURVE, 1'b0);
      // A restart on an ignored kind still clears the state.
      send_point(16'sd40, 16'sd40, KIND_CUBIC, 1'b1);
      send_point(16'sd1, 16'sd2, KIND_CONIC, 1'b0);
      send_point(16'sd3, 16'sd4, KIND_ON_CURVE, 1'b0);
      send_point(16'sd8, 16'sd8, KIND_CONIC, 1'b0);
      // A restart on an on-curve point drops the pending control.
      send_point(16'sd9, -16'sd9, KIND_ON_CURVE, 1'b1);
      send_point(-16'sd7, -16'sd7, KIND_CONIC, 1'b0);
      send_point(COORD_MAX, COORD_MIN, KIND_CONIC, 1'b1);
      send_point(COORD_MIN, COORD_MIN, KIND_ON_CURVE, 1'b0);
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      reset <= 1'b1;
      push <= 1'b0;
      req_point_x <= '0;
      req_point_y <= '0;
      req_point_kind <= KIND_ON_CURVE;
      req_outline_start <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_STEPS_ADDR;
      pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      directed_points();

      set_steps(6'd0);
      random_points(25);
      set_steps(6'd63);
      random_points(15);
      set_steps(6'd1);
      random_points(25);

      // The vertex side holds off while points keep coming, then the point
      // side pauses until everything has drained.
      set_steps(STEPS_BITS'($urandom_range(2, 8)));
      long_hold_req = 1'b1;
      random_points(15);
      wait_drained(0);
      random_points(15);

      set_steps(MAX_STEPS);
      random_points(10);

      set_steps(STEPS_BITS'($urandom_range(0, 10)));
      calm = 1'b1;
      random_points(40);

      wait_drained(SETTLE_CYCLES);

      if (vertices_waiting != 0) begin
         $display("%0t: %0d expected vertices never arrived", $time, vertices_waiting);
      end
      $display("Covered %0d outline points (conic chains, open conics, ignored kinds, restarts)",
               points_sent);
      $display("over %0d steps settings with a long output stall; %0d vertices compared.",
               settings_used, vertices_checked);
      if (check_failures == 0 && vertices_waiting == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/gof_pkg.sv
rtl/gof_fifo.sv
rtl/gof_recip.sv
rtl/gof_front.sv
rtl/gof_back.sv
rtl/glyph_outline_flattener.sv
tb/glyph_outline_flattener_checker.sv
tb/glyph_outline_flattener_test.sv
